// ===== hw/rtl/mecodo_pkg.sv =====
// Shared types and constants for the mecanum odometry block.
// Holds the payload structs, register indexes and serial unit interfaces.
// No dependencies.
package mecodo_pkg;

	localparam int WORK_W = 192;
	localparam int MUL_B_W = 64;
	localparam int K_W = 55;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int DEFAULT_TICK_WIDTH = 32;
	localparam int DEFAULT_FRAC_BITS = 16;

	// 2*pi*1e6 scaled by 2^32.
	localparam logic [K_W-1:0] TWO_PI_MEGA_Q32 = 55'd26986075409044038;

	localparam logic [CFG_IDX_W-1:0] REG_GEAR_RATIO = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_LENGTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_RES = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INT = 3'd5;

	typedef struct packed {
		logic signed [31:0] tick_front_left;
		logic signed [31:0] tick_front_right;
		logic signed [31:0] tick_rear_left;
		logic signed [31:0] tick_rear_right;
		logic [47:0] stamp_us;
	} in_t;

	typedef struct packed {
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] yaw_rate;
		logic [47:0] out_stamp_us;
		logic dt_zero;
	} out_t;

	typedef struct packed {
		logic start;
		logic [WORK_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic done;
		logic [WORK_W-1:0] prod;
	} mul_stat_t;

	typedef struct packed {
		logic start;
		logic neg;
		logic [WORK_W-1:0] num;
		logic [WORK_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic signed [31:0] quot;
	} div_stat_t;

endpackage

// ===== hw/rtl/mecanum_odometry_from_ticks.sv =====
// Mecanum odometry from encoder ticks: top level.
// Unused samples and the first used sample give no beat.
// A used sample runs its products through the shared bit-serial multiplier and its quotients
// through the 33-step divider; with a zero half-length sum the last division is skipped, and a
// zero time step goes straight to the result beat.
// One sample is in work at a time; input is taken again once the result beat is loaded.
// Reset clears the registers to their defaults and the history to zero.
module mecanum_odometry_from_ticks import mecodo_pkg::*; #(
	parameter int TICK_WIDTH = DEFAULT_TICK_WIDTH,
	parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_t out_data,
	input logic cfg_wr_en,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	mecodo_top_core #(
		.TICK_WIDTH(TICK_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

endmodule

// ===== hw/rtl/mecodo_smul.sv =====
// Shift-and-add multiplier, one multiplier bit per cycle.
// Depends on mecodo_pkg for the request and status structs.
module mecodo_smul import mecodo_pkg::*; (
	input logic clk,
	input logic arst_n,
	input mul_req_t req,
	output mul_stat_t stat
);

	logic busy_q;
	logic [WORK_W-1:0] p_q;
	logic [WORK_W-1:0] a_q;
	logic [MUL_B_W-1:0] b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && b_q == '0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			p_q <= '0;
			a_q <= req.a;
			b_q <= req.b;
		end else if (busy_q && b_q != '0) begin
			if (b_q[0]) begin
				p_q <= p_q + a_q;
			end
			a_q <= {a_q[WORK_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[MUL_B_W-1:1]};
		end
	end

	// The product is final once the multiplier has run out of set bits.
	assign stat.done = busy_q && b_q == '0;
	assign stat.prod = p_q;

endmodule

// ===== hw/rtl/mecodo_sdiv.sv =====
// Restoring divider, one quotient bit per cycle, with signed saturation.
// Depends on mecodo_pkg for the request and status structs.
module mecodo_sdiv import mecodo_pkg::*; (
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output div_stat_t stat
);

	logic busy_q;
	logic done_q;
	logic [5:0] cnt_q;
	logic neg_q;
	logic [WORK_W-1:0] r_q;
	logic [WORK_W-1:0] d_q;
	logic [32:0] q_q;
	logic take;
	logic [32:0] mag;

	assign take = r_q >= d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && cnt_q == '0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// The divisor starts 64 places up: 32 for the fixed scale, 32 for the
	// top quotient bit. Bit 32 of the quotient means the result overflows.
	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q <= req.num;
			d_q <= {req.den[WORK_W-65:0], 64'd0};
			cnt_q <= 6'd32;
			neg_q <= req.neg;
			q_q <= '0;
		end else if (busy_q) begin
			if (take) begin
				r_q <= r_q - d_q;
			end
			q_q <= {q_q[31:0], take};
			d_q <= {1'b0, d_q[WORK_W-1:1]};
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_comb begin
		if (neg_q) begin
			mag = (q_q > 33'h080000000) ? 33'h080000000 : q_q;
			stat.quot = -$signed(mag[31:0]);
		end else begin
			mag = (q_q > 33'h07FFFFFFF) ? 33'h07FFFFFFF : q_q;
			stat.quot = $signed(mag[31:0]);
		end
	end

	assign stat.done = done_q;

endmodule

// ===== hw/rtl/mecodo_top_core.sv =====
// Sequencer of the odometry block: registers, sample history and datapath control.
// Depends on mecodo_pkg, mecodo_smul and mecodo_sdiv.
module mecodo_top_core import mecodo_pkg::*; #(
	parameter int TICK_WIDTH = DEFAULT_TICK_WIDTH,
	parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_t out_data,
	input logic cfg_wr_en,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DW = TICK_WIDTH + 1;
	localparam int SW = TICK_WIDTH + 3;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_PREP = 4'd1;
	localparam logic [3:0] S_DEN = 4'd2;
	localparam logic [3:0] S_DENZ = 4'd3;
	localparam logic [3:0] S_RS = 4'd4;
	localparam logic [3:0] S_RK = 4'd5;
	localparam logic [3:0] S_DIV = 4'd6;
	localparam logic [3:0] S_FIN = 4'd7;

	logic [3:0] state_q;

	logic [15:0] gear_q;
	logic [31:0] radius_q;
	logic [31:0] hlen_q;
	logic [31:0] hwid_q;
	logic [15:0] tres_q;
	logic [15:0] intv_q;

	logic signed [TICK_WIDTH-1:0] prev_q [4];
	logic [47:0] pstamp_q;
	logic [15:0] phase_q;
	logic seen_q;

	logic signed [DW-1:0] d_q [4];
	logic signed [48:0] dt_q;
	logic [47:0] stamp_q;
	logic [SW-1:0] sabs_q [3];
	logic [2:0] sneg_q;
	logic dtneg_q;
	logic dtzero_q;
	logic [WORK_W-1:0] den_q;
	logic [WORK_W-1:0] denz_q;
	logic [1:0] axis_q;
	logic signed [31:0] res_q [3];
	out_t out_q;
	logic out_valid_q;

	mul_req_t mreq_q;
	mul_stat_t mstat;
	div_req_t dreq_q;
	div_stat_t dstat;

	logic signed [TICK_WIDTH-1:0] cur [4];
	logic accept;
	logic used;
	logic [16:0] phase_inc;
	logic [15:0] intv_eff;
	logic [15:0] gear_eff;
	logic [15:0] tres_eff;
	logic [31:0] gt;
	logic [32:0] hsum;
	logic signed [SW-1:0] sx;
	logic signed [SW-1:0] sy;
	logic signed [SW-1:0] sz;
	logic [48:0] dt_abs;

	mecodo_smul u_smul (
		.clk(clk),
		.arst_n(arst_n),
		.req(mreq_q),
		.stat(mstat)
	);

	mecodo_sdiv u_sdiv (
		.clk(clk),
		.arst_n(arst_n),
		.req(dreq_q),
		.stat(dstat)
	);

	assign in_ready = state_q == S_IDLE;
	assign accept = in_valid && in_ready;
	assign used = phase_q == '0;
	assign intv_eff = (intv_q == '0) ? 16'd1 : intv_q;
	assign gear_eff = (gear_q == '0) ? 16'd1 : gear_q;
	assign tres_eff = (tres_q == '0) ? 16'd1 : tres_q;
	assign phase_inc = {1'b0, phase_q} + 17'd1;
	assign gt = gear_eff * tres_eff;
	assign hsum = {1'b0, hlen_q} + {1'b0, hwid_q};

	// Counts wider than the field read as zero-extended.
	assign cur[0] = TICK_WIDTH'($unsigned(in_data.tick_front_left));
	assign cur[1] = TICK_WIDTH'($unsigned(in_data.tick_front_right));
	assign cur[2] = TICK_WIDTH'($unsigned(in_data.tick_rear_left));
	assign cur[3] = TICK_WIDTH'($unsigned(in_data.tick_rear_right));

	assign sx = SW'(d_q[0]) + SW'(d_q[1]) + SW'(d_q[2]) + SW'(d_q[3]);
	assign sy = SW'(d_q[1]) + SW'(d_q[2]) - SW'(d_q[0]) - SW'(d_q[3]);
	assign sz = SW'(d_q[1]) + SW'(d_q[3]) - SW'(d_q[0]) - SW'(d_q[2]);
	assign dt_abs = dt_q[48] ? 49'(-dt_q) : 49'(dt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gear_q <= 16'd1;
			radius_q <= 32'd65536;
			hlen_q <= 32'd65536;
			hwid_q <= 32'd65536;
			tres_q <= 16'd42;
			intv_q <= 16'd1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_GEAR_RATIO: gear_q <= cfg_data[15:0];
				REG_WHEEL_RADIUS: radius_q <= cfg_data;
				REG_HALF_LENGTH: hlen_q <= cfg_data;
				REG_HALF_WIDTH: hwid_q <= cfg_data;
				REG_TICK_RES: tres_q <= cfg_data[15:0];
				REG_SAMPLE_INT: intv_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= '0;
			seen_q <= 1'b0;
			pstamp_q <= '0;
			for (int i = 0; i < 4; i++) begin
				prev_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
			mreq_q.start <= 1'b0;
			dreq_q.start <= 1'b0;
			axis_q <= '0;
		end else begin
			mreq_q.start <= 1'b0;
			dreq_q.start <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						phase_q <= (phase_inc >= {1'b0, intv_eff}) ? '0 : phase_inc[15:0];
						if (used) begin
							for (int i = 0; i < 4; i++) begin
								d_q[i] <= DW'(cur[i]) - DW'(prev_q[i]);
								prev_q[i] <= cur[i];
							end
							dt_q <= $signed({1'b0, in_data.stamp_us})
								- $signed({1'b0, pstamp_q});
							stamp_q <= in_data.stamp_us;
							pstamp_q <= in_data.stamp_us;
							seen_q <= 1'b1;
							if (seen_q) begin
								state_q <= S_PREP;
							end
						end
					end
				end
				S_PREP: begin
					sabs_q[0] <= sx[SW-1] ? SW'(-sx) : SW'(sx);
					sabs_q[1] <= sy[SW-1] ? SW'(-sy) : SW'(sy);
					sabs_q[2] <= sz[SW-1] ? SW'(-sz) : SW'(sz);
					sneg_q <= {sz[SW-1], sy[SW-1], sx[SW-1]};
					dtneg_q <= dt_q[48];
					dtzero_q <= dt_q == '0;
					for (int i = 0; i < 3; i++) begin
						res_q[i] <= '0;
					end
					axis_q <= '0;
					if (dt_q == '0) begin
						state_q <= S_FIN;
					end else begin
						mreq_q.start <= 1'b1;
						mreq_q.a <= WORK_W'({gt, 2'b00});
						mreq_q.b <= MUL_B_W'(dt_abs);
						state_q <= S_DEN;
					end
				end
				S_DEN: begin
					if (mstat.done) begin
						den_q <= mstat.prod;
						mreq_q.start <= 1'b1;
						mreq_q.a <= mstat.prod;
						mreq_q.b <= MUL_B_W'(hsum);
						state_q <= S_DENZ;
					end
				end
				S_DENZ: begin
					if (mstat.done) begin
						denz_q <= mstat.prod;
						mreq_q.start <= 1'b1;
						mreq_q.a <= WORK_W'(radius_q);
						mreq_q.b <= MUL_B_W'(sabs_q[0]);
						state_q <= S_RS;
					end
				end
				S_RS: begin
					if (mstat.done) begin
						mreq_q.start <= 1'b1;
						mreq_q.a <= mstat.prod;
						mreq_q.b <= MUL_B_W'(TWO_PI_MEGA_Q32);
						state_q <= S_RK;
					end
				end
				S_RK: begin
					if (mstat.done) begin
						if (axis_q == 2'd2 && hsum == '0) begin
							state_q <= S_FIN;
						end else begin
							dreq_q.start <= 1'b1;
							dreq_q.neg <= sneg_q[axis_q] ^ dtneg_q;
							if (axis_q == 2'd2) begin
								dreq_q.num <= mstat.prod << FRAC_BITS;
								dreq_q.den <= denz_q;
							end else begin
								dreq_q.num <= mstat.prod;
								dreq_q.den <= den_q;
							end
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (dstat.done) begin
						res_q[axis_q] <= dstat.quot;
						if (axis_q == 2'd2) begin
							state_q <= S_FIN;
						end else begin
							axis_q <= axis_q + 2'd1;
							mreq_q.start <= 1'b1;
							mreq_q.a <= WORK_W'(radius_q);
							mreq_q.b <= MUL_B_W'(sabs_q[axis_q + 2'd1]);
							state_q <= S_RS;
						end
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_q.vel_x <= res_q[0];
						out_q.vel_y <= res_q[1];
						out_q.yaw_rate <= res_q[2];
						out_q.out_stamp_us <= stamp_q;
						out_q.dt_zero <= dtzero_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
